// File: rtl/core/sedw_pkg.sv
// shared types and codes for the service entry descriptor walker
`timescale 1ns / 1ps
`default_nettype none

package sedw_pkg;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_DESC    = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_OVERRUN = 2'd3;

  // tag classes
  localparam logic [1:0] CLASS_UNKNOWN = 2'd0;
  localparam logic [1:0] CLASS_FIRST   = 2'd1;
  localparam logic [1:0] CLASS_SECOND  = 2'd2;

  // register word index in the configuration space
  localparam logic REG_KNOWN_TAG_FIRST  = 1'b0;
  localparam logic REG_KNOWN_TAG_SECOND = 1'b1;

  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [7:0] KNOWN_TAG_FIRST_RST  = 8'd72;
  localparam logic [7:0] KNOWN_TAG_SECOND_RST = 8'd207;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       entry_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] service_id;
    logic        eit_schedule;
    logic        eit_present_following;
    logic [2:0]  running_status;
    logic        free_ca_mode;
    logic [11:0] loop_length;
    logic [7:0]  descriptor_tag;
    logic [7:0]  descriptor_length;
    logic [11:0] descriptor_offset;
    logic [1:0]  tag_class;
    logic        last;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/sedw_parser.sv
// byte-wise parser state: header capture and descriptor loop walk
`timescale 1ns / 1ps
`default_nettype none

module sedw_parser
  import sedw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire in_item_t   item,
  input  wire logic [7:0] known_tag_first,
  input  wire logic [7:0] known_tag_second,
  output logic            res_valid,
  output out_item_t       res
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_TAG    = 3'd2;
  localparam logic [2:0] PH_LEN    = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  hidx_r, hidx_nxt;
  logic [15:0] sid_r, sid_nxt;
  logic [5:0]  flags_r, flags_nxt;
  logic [11:0] loop_rem_r, loop_rem_nxt;
  logic [7:0]  body_rem_r, body_rem_nxt;
  logic [11:0] loop_off_r, loop_off_nxt;
  logic [7:0]  tag_r, tag_nxt;

  logic [2:0]  ph_cur;
  logic [2:0]  hidx_cur;
  logic [7:0]  b;
  logic [11:0] need;
  logic [11:0] total;
  logic [11:0] rem_after;
  logic [11:0] off_after;
  logic [7:0]  body_dec;
  logic [1:0]  cls;
  logic        ok;
  out_item_t   r;

  assign b         = item.data_byte;
  assign ph_cur    = item.entry_start ? PH_HEADER : phase_r;
  assign hidx_cur  = item.entry_start ? 3'd0 : hidx_r;
  assign need      = {4'd0, b} + 12'd2;
  assign total     = loop_off_r + loop_rem_r;
  assign rem_after = loop_rem_r - need;
  assign off_after = loop_off_r + need;
  assign body_dec  = (body_rem_r != 8'd0) ? body_rem_r - 8'd1 : body_rem_r;

  // first register wins when both match
  always_comb begin
    priority if (tag_r == known_tag_first) begin
      cls = CLASS_FIRST;
    end else if (tag_r == known_tag_second) begin
      cls = CLASS_SECOND;
    end else begin
      cls = CLASS_UNKNOWN;
    end
  end

  always_comb begin
    phase_nxt    = ph_cur;
    hidx_nxt     = hidx_cur;
    sid_nxt      = sid_r;
    flags_nxt    = flags_r;
    loop_rem_nxt = loop_rem_r;
    body_rem_nxt = body_rem_r;
    loop_off_nxt = loop_off_r;
    tag_nxt      = tag_r;
    ok           = 1'b0;

    r.result_kind           = KIND_HEADER;
    r.service_id            = sid_r;
    r.eit_schedule          = flags_r[5];
    r.eit_present_following = flags_r[4];
    r.running_status        = flags_r[3:1];
    r.free_ca_mode          = flags_r[0];
    r.loop_length           = 12'd0;
    r.descriptor_tag        = 8'd0;
    r.descriptor_length     = 8'd0;
    r.descriptor_offset     = 12'd0;
    r.tag_class             = CLASS_UNKNOWN;
    r.last                  = 1'b0;

    unique case (ph_cur)
      PH_HEADER: begin
        unique case (hidx_cur)
          3'd0: begin
            sid_nxt  = {b, 8'd0};
            hidx_nxt = 3'd1;
          end
          3'd1: begin
            sid_nxt  = {sid_r[15:8], b};
            hidx_nxt = 3'd2;
          end
          3'd2: begin
            flags_nxt = {b[1], b[0], 4'd0};
            hidx_nxt  = 3'd3;
          end
          3'd3: begin
            flags_nxt    = {flags_r[5:4], b[7:5], b[4]};
            loop_rem_nxt = {b[3:0], 8'd0};
            hidx_nxt     = 3'd4;
          end
          default: begin
            loop_rem_nxt  = {loop_rem_r[11:8], b};
            loop_off_nxt  = 12'd0;
            hidx_nxt      = 3'd0;
            ok            = 1'b1;
            r.loop_length = {loop_rem_r[11:8], b};
            if ({loop_rem_r[11:8], b} == 12'd0) begin
              phase_nxt = PH_IDLE;
              r.last    = 1'b1;
            end else begin
              phase_nxt = PH_TAG;
            end
          end
        endcase
      end
      PH_TAG: begin
        tag_nxt   = b;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        ok                  = 1'b1;
        r.loop_length       = total;
        r.descriptor_tag    = tag_r;
        r.descriptor_length = b;
        r.descriptor_offset = loop_off_r;
        r.tag_class         = cls;
        if (need > loop_rem_r) begin
          // descriptor runs past the loop
          phase_nxt     = PH_IDLE;
          r.result_kind = KIND_OVERRUN;
          r.last        = 1'b1;
        end else begin
          loop_rem_nxt  = rem_after;
          loop_off_nxt  = off_after;
          body_rem_nxt  = b;
          r.result_kind = KIND_DESC;
          r.last        = (b == 8'd0) && (rem_after == 12'd0);
          if (b != 8'd0) begin
            phase_nxt = PH_BODY;
          end else if (rem_after == 12'd0) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_TAG;
          end
        end
      end
      PH_BODY: begin
        body_rem_nxt = body_dec;
        if (body_dec == 8'd0) begin
          if (loop_rem_r == 12'd0) begin
            phase_nxt           = PH_IDLE;
            ok                  = 1'b1;
            r.result_kind       = KIND_END;
            r.loop_length       = loop_off_r;
            r.descriptor_offset = loop_off_r;
            r.last              = 1'b1;
          end else begin
            phase_nxt = PH_TAG;
          end
        end
      end
      default: begin
        // idle or unused code: byte dropped
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  assign res_valid = take & ok;
  assign res       = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      hidx_r     <= 3'd0;
      sid_r      <= 16'd0;
      flags_r    <= 6'd0;
      loop_rem_r <= 12'd0;
      body_rem_r <= 8'd0;
      loop_off_r <= 12'd0;
      tag_r      <= 8'd0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      hidx_r     <= hidx_nxt;
      sid_r      <= sid_nxt;
      flags_r    <= flags_nxt;
      loop_rem_r <= loop_rem_nxt;
      body_rem_r <= body_rem_nxt;
      loop_off_r <= loop_off_nxt;
      tag_r      <= tag_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sedw_out_skid.sv
// result register with a skid entry
`timescale 1ns / 1ps
`default_nettype none

module sedw_out_skid
  import sedw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_item_t push_data,
  output logic           full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_item_t main_r;
  out_item_t skid_r;
  logic      main_take;

  assign main_take = main_v_r & ~out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (main_take) begin
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || main_take) begin
        main_v_nxt = 1'b1;
      end else begin
        skid_v_nxt = 1'b1;
      end
    end else if (main_take) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (main_take) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (!main_v_r || main_take) begin
        main_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/service_entry_descriptor_walker_top.sv
// top level of the service entry descriptor walker
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                   payload
// in_       input      in_valid/in_stall           in_data  (data_byte, entry_start)
// out_      output     out_valid/out_stall         out_data (header/descriptor/end/overrun)
// cfg_      input      cfg_psel/cfg_penable/pready cfg_paddr/cfg_pwdata/cfg_prdata
//
// one byte is taken per cycle while in_stall is low; an accepted byte's result, if any, is
// written at that edge into the result register that drives out_, or into the skid entry
// a skid entry behind the result register holds one more result while the output
// is stalled, so input keeps flowing until a second result is waiting
// in_stall rises only once both entries hold results
// rst_n is synchronous and active low: parser idle, tag registers 72 and 207
// bytes without entry_start while idle are dropped without a result

module service_entry_descriptor_walker_top
  import sedw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // byte stream in
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  // results out
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  // configuration
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  logic [7:0] known_tag_first_r;
  logic [7:0] known_tag_second_r;
  logic       cfg_wr;
  logic       take;
  logic       res_valid;
  out_item_t  res;
  logic       full;

  // register file: word index from cfg_paddr[2], byte lanes below are ignored
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_tag_first_r  <= KNOWN_TAG_FIRST_RST;
      known_tag_second_r <= KNOWN_TAG_SECOND_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_KNOWN_TAG_FIRST:  known_tag_first_r  <= cfg_pwdata[7:0];
        REG_KNOWN_TAG_SECOND: known_tag_second_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_KNOWN_TAG_FIRST:  cfg_prdata = {24'd0, known_tag_first_r};
      REG_KNOWN_TAG_SECOND: cfg_prdata = {24'd0, known_tag_second_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // a byte transfer goes through as long as the skid entry is free
  assign in_stall = full;
  assign take     = in_valid & ~full;

  sedw_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .item             (in_data),
    .known_tag_first  (known_tag_first_r),
    .known_tag_second (known_tag_second_r),
    .res_valid        (res_valid),
    .res              (res)
  );

  sedw_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
